>>> rtl/pfv_pkg.sv
// Package for the particle force and Verlet step block.
// Holds register defaults, the queue entry, result and config types, the
// sequencer states and the 32-bit clamp. Depends on nothing.
package pfv_pkg;

  localparam int QDEPTH = 2;

  localparam logic [30:0] CUT_RST  = 31'd65536;
  localparam logic [30:0] MIN_RST  = 31'd6554;
  localparam logic [30:0] INVM_RST = 31'd65536;
  localparam logic [30:0] DT_RST   = 31'd66;
  localparam logic [30:0] SIZE_RST = 31'd6553600;

  localparam logic signed [65:0] Q_MAX = 66'sd2147483647;
  localparam logic signed [65:0] Q_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {
    REG_CUTOFF    = 3'd0,
    REG_MIN_R     = 3'd1,
    REG_INV_MASS  = 3'd2,
    REG_TIME_STEP = 3'd3,
    REG_DOMAIN    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [30:0] cutoff;
    logic [30:0] min_r;
    logic [30:0] inv_mass;
    logic [30:0] dt;
    logic [30:0] size;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_vx;
    logic signed [31:0] own_vy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               do_force;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               sat;
  } result_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clamp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_CUT, S_MIN, S_MAXR, S_SQRT, S_SPREP,
    S_DIVS, S_FINS, S_PMUL, S_PFIN, S_XMUL, S_XPREP, S_DIVX, S_XFIN,
    S_YMUL, S_YPREP, S_DIVY, S_YFIN, S_CHK, S_AMUL, S_VUPD, S_VMUL,
    S_PUPD, S_BNC, S_BCLAMP, S_OUT
  } back_state_e;

  function automatic clamp_t clamp32(input logic signed [65:0] v);
    clamp_t c;
    c.sat = 1'b0;
    c.val = v[31:0];
    if (v > Q_MAX) begin
      c.sat = 1'b1;
      c.val = 32'sh7FFFFFFF;
    end else if (v < Q_MIN) begin
      c.sat = 1'b1;
      c.val = 32'sh80000000;
    end
    return c;
  endfunction

endpackage

>>> rtl/pfv_front.sv
// Front end: takes input words, forms the neighbour offset, classifies it
// against the cutoff box and queues the words that need work.
// Depends on pfv_pkg.
module pfv_front import pfv_pkg::*; #(
  parameter int Depth = QDEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_vx_i,
  input  logic signed [31:0] own_vy_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic               other_valid_i,
  input  logic               last_neighbour_i,
  input  logic [30:0]        cutoff_i,
  output logic               q_valid_o,
  output item_t              q_item_o,
  input  logic               q_take_i
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic signed [32:0] dx, dy, cut;
  logic              in_x, in_y, keep, wr, rd;
  item_t             item;

  assign dx   = $signed({other_x_i[31], other_x_i}) - $signed({own_x_i[31], own_x_i});
  assign dy   = $signed({other_y_i[31], other_y_i}) - $signed({own_y_i[31], own_y_i});
  assign cut  = $signed({2'b00, cutoff_i});
  assign in_x = (dx <= cut) && (dx >= -cut);
  assign in_y = (dy <= cut) && (dy >= -cut);

  always_comb begin
    item.own_x    = own_x_i;
    item.own_y    = own_y_i;
    item.own_vx   = own_vx_i;
    item.own_vy   = own_vy_i;
    item.dx       = dx[31:0];
    item.dy       = dy[31:0];
    item.do_force = other_valid_i && in_x && in_y;
    item.last     = last_neighbour_i;
  end

  assign keep      = item.do_force || item.last;
  assign full      = (cnt_q == CW'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign wr        = push && !full && keep;
  assign rd        = q_take_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count beyond depth");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !keep && !rd) |=> $stable(cnt_q))
    else $error("dropped word changed queue fill");

endmodule

>>> rtl/pfv_back.sv
// Back end: sequencer over one shared multiplier, a radix-2 square root
// and a radix-2 divider; accumulates force, integrates, bounces and holds
// the result word. Depends on pfv_pkg.
module pfv_back import pfv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    q_valid_i,
  input  item_t   q_item_i,
  output logic    q_take_o,
  input  logic    pop_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd63;

  back_state_e        state_q, state_d;
  item_t              cur_q, cur_d;
  logic signed [63:0] prod_q, prod_d;
  logic [63:0]        r2_q, r2_d, n_q, n_d, dvd_q, dvd_d;
  logic [34:0]        rem_q, rem_d;
  logic [31:0]        root_q, root_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [47:0]        dvs_q, dvs_d, drem_q, drem_d;
  logic               neg_q, neg_d, sat_q, sat_d, axis_q, axis_d, bpass_q, bpass_d;
  logic signed [31:0] s_q, s_d, p_q, p_d, accx_q, accx_d, accy_q, accy_d;
  logic signed [31:0] v_q, v_d, rx_q, rx_d, rvx_q, rvx_d;
  logic signed [33:0] pos_q, pos_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [36:0]        rs, trial;
  logic [48:0]        div_sh;
  logic               div_ge, refl;
  logic [47:0]        div_rem_n, r2_hi;
  logic [63:0]        div_dvd_n, mx, pmag;
  logic signed [65:0] qv;
  logic signed [33:0] rmc, rmag, size34;
  logic signed [31:0] fin;
  clamp_t             c_a, c_b;

  assign mp        = ma * mb;
  assign div_sh    = {drem_q, dvd_q[63]};
  assign div_ge    = div_sh >= {1'b0, dvs_q};
  assign div_rem_n = div_ge ? 48'(div_sh - {1'b0, dvs_q}) : div_sh[47:0];
  assign div_dvd_n = {dvd_q[62:0], div_ge};
  assign qv        = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
  assign rs        = {rem_q, n_q[63:62]};
  assign trial     = {3'b000, root_q, 2'b01};
  assign mx        = (r2_q < $unsigned(prod_q)) ? $unsigned(prod_q) : r2_q;
  assign rmc       = $signed({2'b00, root_q}) - $signed({3'b000, cfg_i.cutoff});
  assign rmag      = rmc[33] ? -rmc : rmc;
  assign pmag      = prod_q[63] ? $unsigned(-prod_q) : $unsigned(prod_q);
  assign r2_hi     = (r2_q[63:16] == '0) ? 48'd1 : r2_q[63:16];
  assign size34    = $signed({3'b000, cfg_i.size});
  assign q_take_o  = (state_q == S_IDLE) && q_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    state_d = state_q;   cur_d = cur_q;     prod_d = prod_q;   r2_d = r2_q;
    n_d = n_q;           rem_d = rem_q;     root_d = root_q;   cnt_d = cnt_q;
    dvd_d = dvd_q;       dvs_d = dvs_q;     drem_d = drem_q;   neg_d = neg_q;
    sat_d = sat_q;       axis_d = axis_q;   bpass_d = bpass_q; s_d = s_q;
    p_d = p_q;           accx_d = accx_q;   accy_d = accy_q;   v_d = v_q;
    rx_d = rx_q;         rvx_d = rvx_q;     pos_d = pos_q;     out_d = out_q;
    out_valid_d = out_valid_q && !pop_i;
    ma = '0;
    mb = '0;
    c_a = '0;
    c_b = '0;
    refl = 1'b0;
    fin = pos_q[31:0];
    if (state_q == S_DIVS || state_q == S_DIVX || state_q == S_DIVY) begin
      drem_d = div_rem_n;
      dvd_d  = div_dvd_n;
      cnt_d  = cnt_q + 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          cur_d   = q_item_i;
          state_d = q_item_i.do_force ? S_SQX : S_CHK;
        end
      end
      S_SQX: begin
        ma = 33'(cur_q.dx);
        mb = 33'(cur_q.dx);
        prod_d = mp[63:0];
        state_d = S_SQY;
      end
      S_SQY: begin
        r2_d = $unsigned(prod_q);
        ma = 33'(cur_q.dy);
        mb = 33'(cur_q.dy);
        prod_d = mp[63:0];
        state_d = S_CUT;
      end
      S_CUT: begin
        r2_d = r2_q + $unsigned(prod_q);
        ma = {2'b00, cfg_i.cutoff};
        mb = {2'b00, cfg_i.cutoff};
        prod_d = mp[63:0];
        state_d = S_MIN;
      end
      S_MIN: begin
        if (r2_q > $unsigned(prod_q)) begin
          state_d = S_CHK;
        end else begin
          ma = {2'b00, cfg_i.min_r};
          mb = {2'b00, cfg_i.min_r};
          prod_d = mp[63:0];
          state_d = S_MAXR;
        end
      end
      S_MAXR: begin
        if (mx == '0) begin
          state_d = S_CHK;
        end else begin
          r2_d = mx;
          n_d = mx;
          rem_d = '0;
          root_d = '0;
          cnt_d = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (rs >= trial) begin
          rem_d  = 35'(rs - trial);
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rs[34:0];
          root_d = {root_q[30:0], 1'b0};
        end
        n_d = {n_q[61:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = S_SPREP;
        end
      end
      S_SPREP: begin
        dvd_d = {14'd0, rmag[33:0], 16'd0};
        dvs_d = {16'd0, root_q};
        drem_d = '0;
        neg_d = rmc[33];
        cnt_d = '0;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_FINS;
        end
      end
      S_FINS: begin
        c_a = clamp32(qv);
        s_d = c_a.val;
        sat_d = sat_q | c_a.sat;
        state_d = S_PMUL;
      end
      S_PMUL: begin
        ma = 33'(s_q);
        mb = {2'b00, cfg_i.inv_mass};
        prod_d = mp[63:0];
        state_d = S_PFIN;
      end
      S_PFIN: begin
        c_a = clamp32(66'(prod_q >>> 16));
        p_d = c_a.val;
        sat_d = sat_q | c_a.sat;
        state_d = S_XMUL;
      end
      S_XMUL, S_YMUL: begin
        ma = 33'(p_q);
        mb = (state_q == S_XMUL) ? 33'(cur_q.dx) : 33'(cur_q.dy);
        prod_d = mp[63:0];
        state_d = (state_q == S_XMUL) ? S_XPREP : S_YPREP;
      end
      S_XPREP, S_YPREP: begin
        dvd_d = pmag;
        dvs_d = r2_hi;
        drem_d = '0;
        neg_d = prod_q[63];
        cnt_d = '0;
        state_d = (state_q == S_XPREP) ? S_DIVX : S_DIVY;
      end
      S_DIVX: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_XFIN;
        end
      end
      S_DIVY: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_YFIN;
        end
      end
      S_XFIN: begin
        c_a = clamp32(qv);
        c_b = clamp32(66'(accx_q) + 66'(c_a.val));
        accx_d = c_b.val;
        sat_d = sat_q | c_a.sat | c_b.sat;
        state_d = S_YMUL;
      end
      S_YFIN: begin
        c_a = clamp32(qv);
        c_b = clamp32(66'(accy_q) + 66'(c_a.val));
        accy_d = c_b.val;
        sat_d = sat_q | c_a.sat | c_b.sat;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (cur_q.last) begin
          axis_d = 1'b0;
          pos_d = 34'(cur_q.own_x);
          v_d = cur_q.own_vx;
          state_d = S_AMUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AMUL: begin
        ma = axis_q ? 33'(accy_q) : 33'(accx_q);
        mb = {2'b00, cfg_i.dt};
        prod_d = mp[63:0];
        state_d = S_VUPD;
      end
      S_VUPD: begin
        c_a = clamp32(66'(v_q) + 66'(prod_q >>> 16));
        v_d = c_a.val;
        sat_d = sat_q | c_a.sat;
        state_d = S_VMUL;
      end
      S_VMUL: begin
        ma = 33'(v_q);
        mb = {2'b00, cfg_i.dt};
        prod_d = mp[63:0];
        state_d = S_PUPD;
      end
      S_PUPD: begin
        c_a = clamp32(66'(pos_q) + 66'(prod_q >>> 16));
        pos_d = 34'(c_a.val);
        sat_d = sat_q | c_a.sat;
        bpass_d = 1'b0;
        state_d = S_BNC;
      end
      S_BNC: begin
        if (pos_q < 0) begin
          pos_d = -pos_q;
          refl = 1'b1;
        end else if (pos_q > size34) begin
          pos_d = (size34 <<< 1) - pos_q;
          refl = 1'b1;
        end else begin
          state_d = S_BCLAMP;
        end
        if (refl) begin
          if (v_q == 32'sh80000000) begin
            v_d = 32'sh7FFFFFFF;
            sat_d = 1'b1;
          end else begin
            v_d = -v_q;
          end
          if (bpass_q) begin
            state_d = S_BCLAMP;
          end else begin
            bpass_d = 1'b1;
          end
        end
      end
      S_BCLAMP: begin
        if (pos_q < 0) begin
          fin = '0;
          sat_d = 1'b1;
        end else if (pos_q > size34) begin
          fin = {1'b0, cfg_i.size};
          sat_d = 1'b1;
        end
        if (!axis_q) begin
          rx_d = fin;
          rvx_d = v_q;
          axis_d = 1'b1;
          pos_d = 34'(cur_q.own_y);
          v_d = cur_q.own_vy;
          state_d = S_AMUL;
        end else begin
          pos_d = 34'(fin);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || pop_i) begin
          out_d.x = rx_q;
          out_d.y = pos_q[31:0];
          out_d.vx = rvx_q;
          out_d.vy = v_q;
          out_d.sat = sat_q;
          out_valid_d = 1'b1;
          accx_d = '0;
          accy_d = '0;
          sat_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      accx_q      <= '0;
      accy_q      <= '0;
      sat_q       <= 1'b0;
      axis_q      <= 1'b0;
      bpass_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      accx_q      <= accx_d;
      accy_q      <= accy_d;
      sat_q       <= sat_d;
      axis_q      <= axis_d;
      bpass_q     <= bpass_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;   prod_q <= prod_d; r2_q  <= r2_d;   n_q    <= n_d;
    rem_q  <= rem_d;   root_q <= root_d; dvd_q <= dvd_d;  dvs_q  <= dvs_d;
    drem_q <= drem_d;  neg_q  <= neg_d;  s_q   <= s_d;    p_q    <= p_d;
    v_q    <= v_d;     rx_q   <= rx_d;   rvx_q <= rvx_d;  pos_q  <= pos_d;
    out_q  <= out_d;
  end

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || pop_i)) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result word not loaded");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVS || state_q == S_DIVX || state_q == S_DIVY) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_rose_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result word raised outside output step");

endmodule

>>> rtl/particle_force_and_verlet_step.sv
// Sequence: a neighbour inside the cutoff passes the back end through the 32-step
// square root and three 64-step divisions through the shared divider. A neighbour
// outside the cutoff box is dropped at the front unless it is the last word; one
// inside the box but beyond the radius skips the square root and the divisions.
// Throughput: one word at a time in the back end; a finished result waits for pop.
// Reset: registers to their defaults, accumulators and queue cleared.
module particle_force_and_verlet_step import pfv_pkg::*; #(
  parameter int QueueDepth = QDEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] own_x_i,
  input  logic signed [31:0] own_y_i,
  input  logic signed [31:0] own_vx_i,
  input  logic signed [31:0] own_vy_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic               other_valid_i,
  input  logic               last_neighbour_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_vx_o,
  output logic signed [31:0] new_vy_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  cfg_t    cfg_q;
  logic    q_valid, q_take, res_valid;
  item_t   q_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff   <= CUT_RST;
      cfg_q.min_r    <= MIN_RST;
      cfg_q.inv_mass <= INVM_RST;
      cfg_q.dt       <= DT_RST;
      cfg_q.size     <= SIZE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CUTOFF:    cfg_q.cutoff   <= cfg_data_i;
        REG_MIN_R:     cfg_q.min_r    <= cfg_data_i;
        REG_INV_MASS:  cfg_q.inv_mass <= cfg_data_i;
        REG_TIME_STEP: cfg_q.dt       <= cfg_data_i;
        REG_DOMAIN:    cfg_q.size     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pfv_front #(.Depth(QueueDepth)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .own_x_i          (own_x_i),
    .own_y_i          (own_y_i),
    .own_vx_i         (own_vx_i),
    .own_vy_i         (own_vy_i),
    .other_x_i        (other_x_i),
    .other_y_i        (other_y_i),
    .other_valid_i    (other_valid_i),
    .last_neighbour_i (last_neighbour_i),
    .cutoff_i         (cfg_q.cutoff),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_take_i         (q_take)
  );

  pfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_take_o    (q_take),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty       = !res_valid;
  assign new_x_o     = res.x;
  assign new_y_o     = res.y;
  assign new_vx_o    = res.vx;
  assign new_vy_o    = res.vy;
  assign saturated_o = res.sat;

endmodule
